// ===== rtl/combination_sequence_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// combination sequence generator: assertion macros
// shared property forms, each clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COMBINATION_SEQUENCE_GENERATOR_CORE_DEFINES_SVH
`define COMBINATION_SEQUENCE_GENERATOR_CORE_DEFINES_SVH

// condition holds at every edge
`define CSG_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("csg: invariant violated");

// antecedent implies consequent in the same cycle
`define CSG_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csg: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csg: next-cycle check failed");

`endif

// ===== rtl/csg_pkg.sv =====
// ----------------------------------------------------------------------------
// csg_pkg
// widths, limits, register indexes and shared types of the combination
// sequence generator
// ----------------------------------------------------------------------------
package csg_pkg;

  // largest pick count and set size
  localparam int MAX_PICK = 8;
  localparam int MAX_SET  = 63;

  // field widths
  localparam int SLOT_W  = 6;   // element number
  localparam int POS_W   = 3;   // slot number
  localparam int PICK_W  = 4;   // pick count register
  localparam int LIMIT_W = 32;  // sequence limit and given count
  localparam int CMP_W   = 8;   // room for set size minus pick plus slot

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LIMIT  = 2'd2;

  // register reset values
  localparam logic [SLOT_W-1:0]  SET_SIZE_RST   = 6'd8;
  localparam logic [PICK_W-1:0]  PICK_COUNT_RST = 4'd3;
  localparam logic [LIMIT_W-1:0] SEQ_LIMIT_RST  = 32'd56;

  // request queue depth
  localparam int REQ_DEPTH = 2;
  localparam int REQ_PTR_W = 1;
  localparam int REQ_CNT_W = 2;

  // head of the request queue as seen by the engine
  typedef struct packed {
    logic valid;
    logic restart;
  } csg_req_t;

endpackage

// ===== rtl/csg_req_queue.sv =====
// ----------------------------------------------------------------------------
// csg_req_queue
// front end: accepts request words and holds them in a short queue
// until the engine takes them
// ----------------------------------------------------------------------------
`include "combination_sequence_generator_core_defines.svh"

module csg_req_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              in_restart,
  output logic              full,
  input  logic              req_pop,
  output csg_pkg::csg_req_t req
);
  import csg_pkg::*;

  logic                 store_r [REQ_DEPTH];
  logic [REQ_PTR_W-1:0] wr_ptr_r;
  logic [REQ_PTR_W-1:0] rd_ptr_r;
  logic [REQ_CNT_W-1:0] cnt_r;
  logic                 do_push;
  logic                 do_pop;

  // handshake qualifiers
  assign full    = (cnt_r == REQ_CNT_W'(REQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = req_pop && (cnt_r != '0);

  // head word
  assign req.valid   = (cnt_r != '0);
  assign req.restart = store_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= in_restart;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + REQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + REQ_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + REQ_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - REQ_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // checks
  `CSG_ASSERT_HOLDS(a_cnt_in_range, cnt_r <= REQ_CNT_W'(REQ_DEPTH))
  `CSG_ASSERT_IMPLIES(a_ptr_match, cnt_r == '0 || cnt_r == REQ_CNT_W'(REQ_DEPTH), wr_ptr_r == rd_ptr_r)

endmodule

// ===== rtl/csg_engine.sv =====
// ----------------------------------------------------------------------------
// csg_engine
// back end: steps the slot registers for one request, then streams the
// combination out one slot per word through an output register
// ----------------------------------------------------------------------------
`include "combination_sequence_generator_core_defines.svh"

module csg_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [csg_pkg::SLOT_W-1:0]   set_size,
  input  logic [csg_pkg::PICK_W-1:0]   pick_count,
  input  logic [csg_pkg::LIMIT_W-1:0]  seq_limit,
  input  csg_pkg::csg_req_t            req,
  output logic                         req_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic                         out_exhausted,
  output logic [csg_pkg::POS_W-1:0]    out_position,
  output logic [csg_pkg::SLOT_W-1:0]   out_element,
  output logic                         out_last
);
  import csg_pkg::*;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t              state_r;
  logic [SLOT_W-1:0]   slots_r [MAX_PICK];
  logic [LIMIT_W-1:0]  count_r;
  logic                exh_r;
  logic [POS_W-1:0]    idx_r;
  logic [POS_W-1:0]    last_idx_r;
  logic                out_valid_r;
  logic                out_exh_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [SLOT_W-1:0]   out_elem_r;
  logic                out_last_r;

  logic [SLOT_W-1:0]   base_slots [MAX_PICK];
  logic [SLOT_W-1:0]   next_slots [MAX_PICK];
  logic [CMP_W-1:0]    bound      [MAX_PICK];
  logic [LIMIT_W-1:0]  base_count;
  logic [CMP_W-1:0]    n_ext;
  logic [CMP_W-1:0]    r_ext;
  logic                exh;
  logic                found;
  logic [POS_W-1:0]    pivot;
  logic [SLOT_W-1:0]   piv_val;
  logic                advance;
  logic                dispatch;
  logic                load;

  // request handoff and output load strobes
  assign dispatch = (state_r == S_IDLE) && req.valid;
  assign req_pop  = dispatch;
  assign load     = (state_r == S_EMIT) && (!out_valid_r || pop);

  // restart applies before the request is served
  assign base_count = req.restart ? '0 : count_r;
  assign n_ext      = CMP_W'(set_size);
  assign r_ext      = CMP_W'(pick_count);

  // classify the request
  assign exh = (pick_count == '0) || (pick_count > PICK_W'(MAX_PICK)) ||
               (r_ext > n_ext) || (base_count >= seq_limit);

  // per-slot start value and upper bound
  always_comb begin
    for (int i = 0; i < MAX_PICK; i++) begin
      base_slots[i] = req.restart ? SLOT_W'(i) : slots_r[i];
      bound[i]      = n_ext - r_ext + CMP_W'(i);
    end
  end

  // rightmost slot that can still be bumped
  always_comb begin
    found = 1'b0;
    pivot = '0;
    for (int i = 0; i < MAX_PICK; i++) begin
      if ((CMP_W'(i) < r_ext) && (CMP_W'(base_slots[i]) < bound[i])) begin
        found = 1'b1;
        pivot = POS_W'(i);
      end
    end
  end

  assign piv_val = base_slots[pivot];
  assign advance = (base_count != '0) && found;

  // bump the pivot and refill the slots to its right
  always_comb begin
    for (int j = 0; j < MAX_PICK; j++) begin
      next_slots[j] = base_slots[j];
      if (advance && (POS_W'(j) >= pivot) && (CMP_W'(j) < r_ext)) begin
        next_slots[j] = piv_val + SLOT_W'(POS_W'(j) - pivot) + SLOT_W'(1);
      end
    end
  end

  // sequencer, slot state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      exh_r       <= 1'b0;
      idx_r       <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PICK; i++) begin
        slots_r[i] <= SLOT_W'(i);
      end
    end else begin
      // output word valid: set on load, cleared when popped
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (dispatch) begin
            for (int i = 0; i < MAX_PICK; i++) begin
              slots_r[i] <= exh ? base_slots[i] : next_slots[i];
            end
            count_r    <= exh ? base_count : base_count + LIMIT_W'(1);
            exh_r      <= exh;
            last_idx_r <= exh ? '0 : POS_W'(pick_count - PICK_W'(1));
            idx_r      <= '0;
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_exh_r   <= exh_r;
            out_pos_r   <= idx_r;
            out_elem_r  <= exh_r ? '0 : slots_r[idx_r];
            out_last_r  <= (idx_r == last_idx_r);
            if (idx_r == last_idx_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + POS_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result ports
  assign empty         = !out_valid_r;
  assign out_exhausted = out_exh_r;
  assign out_position  = out_pos_r;
  assign out_element   = out_elem_r;
  assign out_last      = out_last_r;

  // checks
  `CSG_ASSERT_IMPLIES(a_exh_word, out_valid_r && out_exh_r, out_last_r && out_elem_r == '0)
  `CSG_ASSERT_IMPLIES(a_exh_pos, out_valid_r && out_exh_r, out_pos_r == '0)
  `CSG_ASSERT_IMPLIES(a_idx_bound, state_r == S_EMIT, idx_r <= last_idx_r)
  `CSG_ASSERT_NEXT(a_count_hold, !dispatch, $stable(count_r))
  `CSG_ASSERT_IMPLIES(a_exh_single, state_r == S_EMIT && exh_r, last_idx_r == '0)

endmodule

// ===== rtl/combination_sequence_generator_core.sv =====
// ----------------------------------------------------------------------------
// combination_sequence_generator_core
// lexicographic r-of-n combination generator with queue-style ports
// ----------------------------------------------------------------------------
// Each request word yields one combination as pick_count result words, slot 0
// first, the final one flagged by out_last; a request past the limit or with a
// pick count that is zero, above MAX_PICK or above the set size yields a
// single exhausted word. The engine steps the slot registers, then loads the
// result words one by one into the single output register whenever it is empty
// or being popped, and takes the next request only after loading the last word.
// A two-word request queue takes new requests while the engine works.
// Registers: 0 set_size, 1 pick_count, 2 sequence_limit; write them only when
// no request is pending and all results have been popped.
// ----------------------------------------------------------------------------
module combination_sequence_generator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [csg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_restart,
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_exhausted,
  output logic [csg_pkg::POS_W-1:0]        out_position,
  output logic [csg_pkg::SLOT_W-1:0]       out_element,
  output logic                             out_last
);
  import csg_pkg::*;

  logic [SLOT_W-1:0]  set_size_r;
  logic [PICK_W-1:0]  pick_count_r;
  logic [LIMIT_W-1:0] seq_limit_r;
  csg_req_t           req;
  logic               req_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r   <= SET_SIZE_RST;
      pick_count_r <= PICK_COUNT_RST;
      seq_limit_r  <= SEQ_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_SIZE:   set_size_r   <= cfg_wdata[SLOT_W-1:0];
        REG_PICK_COUNT: pick_count_r <= cfg_wdata[PICK_W-1:0];
        REG_SEQ_LIMIT:  seq_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: request queue
  csg_req_queue u_req_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_restart (in_restart),
    .full       (full),
    .req_pop    (req_pop),
    .req        (req)
  );

  // back end: stepping and streaming
  csg_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .set_size      (set_size_r),
    .pick_count    (pick_count_r),
    .seq_limit     (seq_limit_r),
    .req           (req),
    .req_pop       (req_pop),
    .pop           (pop),
    .empty         (empty),
    .out_exhausted (out_exhausted),
    .out_position  (out_position),
    .out_element   (out_element),
    .out_last      (out_last)
  );

endmodule
